// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks shared by the turn controller modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define HPTC_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hptc assertion failed");

// expression must never be true outside reset
`define HPTC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("hptc forbidden condition seen");

`endif

// ===== rtl/hptc_pkg.sv =====
// ----------------------------------------------------------------------------
// hptc_pkg
// shared widths, constants, codes and control types of the turn controller
// ----------------------------------------------------------------------------
package hptc_pkg;

   localparam int HEAD_W      = 17;
   localparam int TURN_W      = 16;
   localparam int NORM_W      = 24;
   localparam int DRIVE_W     = 16;
   localparam int GAIN_W      = 32;
   localparam int SPEED_W     = 15;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int WORK_W      = 19;
   localparam int NORM_FRAC   = 15;
   localparam int CHUNK_W     = 16;
   localparam int NORM_CH     = 2;
   localparam int DRIVE_SHIFT = 31;
   localparam int FULL_DEG    = 360;

   localparam logic signed [NORM_W-1:0] NORM_ONE     = 24'sd32768;
   localparam logic [NORM_W-1:0]        NORM_POS_MAX = 24'h7FFFFF;
   localparam logic [NORM_W-1:0]        NORM_NEG_MAG = 24'h800000;
   localparam logic signed [NORM_W-1:0] NORM_MIN     = 24'sh800000;

   localparam logic [GAIN_W-1:0]  KP_RESET        = 32'd36962;
   localparam logic [GAIN_W-1:0]  KI_RESET        = 32'd275;
   localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 15'd12000;
   localparam logic [SPEED_W-1:0] THRESHOLD_RESET = 15'd3277;

   localparam logic REQ_START = 1'b0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN,
      CSR_KI_GAIN,
      CSR_MAX_SPEED,
      CSR_DONE_THRESHOLD
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_WRAP,
      OP_TAKE_CUR,
      OP_START,
      OP_IDLE_RES,
      OP_ERR,
      OP_DIV,
      OP_NORM,
      OP_MUL,
      OP_CLAMP,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_start;
      logic running;
      logic div_last;
      logic mul_last;
   } dp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRAP_CUR,
      S_WRAP_WANT,
      S_IDLE_RES,
      S_ERR,
      S_DIV,
      S_NORM,
      S_MUL,
      S_CLAMP,
      S_FINISH
   } ctl_state_type;

endpackage

// ===== rtl/heading_pi_turn_controller.sv =====
// ----------------------------------------------------------------------------
// heading_pi_turn_controller: pi heading controller with angle wrap
// turning sample: wrap, error to target, divide one bit a cycle for NW = 15 + clog2(360 << AFB) bits,
// normalise, sum, multiply by chunks (SUM_CH = ceil(SUM_WIDTH / 16) of the sum), clamp; start or idle: wrap
// next item taken the cycle after the result registers, which waits while the held result is stalled
// sync active-high reset: idle, turn state cleared, gains and limits to defaults, no clearing pass
// ----------------------------------------------------------------------------
module heading_pi_turn_controller #(
   parameter int ANGLE_FRAC_BITS = 6,
   parameter int SUM_WIDTH       = 40
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic signed [hptc_pkg::HEAD_W-1:0]   req_heading,
   input  logic signed [hptc_pkg::TURN_W-1:0]   req_turn_amount,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [hptc_pkg::DRIVE_W-1:0]  rsp_drive,
   output logic                                 rsp_done_res,
   output logic signed [hptc_pkg::NORM_W-1:0]   rsp_error_norm,
   input  logic                                 csr_write,
   input  logic [hptc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hptc_pkg::CSR_W-1:0]           csr_wdata
);
   import hptc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   hptc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   hptc_dp #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .SUM_WIDTH       (SUM_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_heading     (req_heading),
      .req_turn_amount (req_turn_amount),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_drive       (rsp_drive),
      .rsp_done_res    (rsp_done_res),
      .rsp_error_norm  (rsp_error_norm)
   );

endmodule

// ===== rtl/hptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hptc_ctrl
// sequencer of the turn controller: steps the datapath through wrap, divide,
// multiply and clamp, and owns the input and result handshakes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hptc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hptc_pkg::dp_cmd_type    cmd,
   input  hptc_pkg::dp_status_type status
);
   import hptc_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_room;

   assign rsp_room  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_WRAP_CUR;
         end
         S_WRAP_CUR: begin
            if (status.in_range) begin
               priority if (status.is_start) state_in = S_WRAP_WANT;
               else if (status.running) state_in = S_ERR;
               else state_in = S_IDLE_RES;
            end
         end
         S_WRAP_WANT: begin
            if (status.in_range) state_in = S_FINISH;
         end
         S_IDLE_RES: state_in = S_FINISH;
         S_ERR:      state_in = S_DIV;
         S_DIV: begin
            if (status.div_last) state_in = S_NORM;
         end
         S_NORM:     state_in = S_MUL;
         S_MUL: begin
            if (status.mul_last) state_in = S_CLAMP;
         end
         S_CLAMP:    state_in = S_FINISH;
         S_FINISH: begin
            if (rsp_room) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_IDLE:      cmd.op = req_valid ? OP_LOAD : OP_NONE;
         S_WRAP_CUR:  cmd.op = status.in_range ? OP_TAKE_CUR : OP_WRAP;
         S_WRAP_WANT: cmd.op = status.in_range ? OP_START : OP_WRAP;
         S_IDLE_RES:  cmd.op = OP_IDLE_RES;
         S_ERR:       cmd.op = OP_ERR;
         S_DIV:       cmd.op = OP_DIV;
         S_NORM:      cmd.op = OP_NORM;
         S_MUL:       cmd.op = OP_MUL;
         S_CLAMP:     cmd.op = OP_CLAMP;
         S_FINISH:    cmd.op = rsp_room ? OP_RESULT : OP_NONE;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (state_ff == S_FINISH && rsp_room) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `HPTC_ASSERT_CLK(a_finish_loads, clock, reset, (state_ff == S_FINISH && rsp_room) |=> (rsp_valid_ff && state_ff == S_IDLE))
   `HPTC_ASSERT_CLK(a_div_holds, clock, reset, (state_ff == S_DIV && !status.div_last) |=> (state_ff == S_DIV))
   `HPTC_ASSERT_CLK(a_mul_ends, clock, reset, (state_ff == S_MUL && status.mul_last) |=> (state_ff == S_CLAMP))

endmodule

// ===== rtl/hptc_dp.sv =====
// ----------------------------------------------------------------------------
// hptc_dp
// datapath of the turn controller: angle wrap, shortest error, serial divide,
// saturating sum, chunked gain multiply, clamp, config and result registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hptc_dp #(
   parameter int ANGLE_FRAC_BITS = 6,
   parameter int SUM_WIDTH       = 40
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  hptc_pkg::dp_cmd_type                      cmd,
   output hptc_pkg::dp_status_type                   status,
   input  logic                                      req_type,
   input  logic signed [hptc_pkg::HEAD_W-1:0]        req_heading,
   input  logic signed [hptc_pkg::TURN_W-1:0]        req_turn_amount,
   input  logic                                      csr_write,
   input  logic [hptc_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [hptc_pkg::CSR_W-1:0]                csr_wdata,
   output logic signed [hptc_pkg::DRIVE_W-1:0]       rsp_drive,
   output logic                                      rsp_done_res,
   output logic signed [hptc_pkg::NORM_W-1:0]        rsp_error_norm
);
   import hptc_pkg::*;

   localparam int FULL_TURN = FULL_DEG << ANGLE_FRAC_BITS;
   localparam int AW        = $clog2(FULL_TURN);
   localparam int EW        = AW + 2;
   localparam int DW        = AW + 4;
   localparam int NW        = AW + NORM_FRAC;
   localparam int DCW       = $clog2(NW);
   localparam int SW        = SUM_WIDTH;
   localparam int SW1       = SW + 1;
   localparam int SUM_CH    = (SW + CHUNK_W - 1) / CHUNK_W;
   localparam int MSTEPS    = NORM_CH + SUM_CH;
   localparam int MCW       = $clog2(MSTEPS);
   localparam int NCW       = $clog2(NORM_CH);
   localparam int CSW       = $clog2(SUM_CH);
   localparam int CIW       = (CSW > NCW) ? CSW : NCW;
   localparam int NXW       = NORM_CH * CHUNK_W;
   localparam int SXW       = SUM_CH * CHUNK_W;
   localparam int PW        = SW + GAIN_W + 2;
   localparam int PROD_W    = CHUNK_W + GAIN_W + 2;

   localparam logic signed [WORK_W-1:0] FT_WORK = WORK_W'(FULL_TURN);
   localparam logic signed [DW-1:0]     FT_D    = DW'(FULL_TURN);
   localparam logic signed [SW:0]       SUM_MAX = {2'b00, {(SW-1){1'b1}}};
   localparam logic signed [SW:0]       SUM_MIN = {2'b11, {(SW-1){1'b0}}};

   // config registers
   logic [GAIN_W-1:0]  kp_ff, kp_in, ki_ff, ki_in;
   logic [SPEED_W-1:0] max_ff, max_in, thr_ff, thr_in;

   // item and turn state
   logic                       type_ff, type_in;
   logic signed [TURN_W-1:0]   turn_ff, turn_in;
   logic signed [WORK_W-1:0]   ang_ff, ang_in;
   logic [AW-1:0]              cur_ff, cur_in;
   logic [AW-1:0]              target_ff, target_in;
   logic [AW-1:0]              mag_ff, mag_in;
   logic signed [SW-1:0]       sum_ff, sum_in;
   logic                       running_ff, running_in;
   logic signed [EW-1:0]       err_ff, err_in;

   // divider
   logic [AW:0]                rem_ff, rem_in;
   logic [NW-1:0]              quo_ff, quo_in;
   logic [DCW-1:0]             dcnt_ff, dcnt_in;

   // result staging and multiply
   logic signed [NORM_W-1:0]   norm_ff, norm_in;
   logic signed [DRIVE_W-1:0]  drive_ff, drive_in;
   logic                       done_ff, done_in;
   logic signed [PW-1:0]       acc_ff, acc_in;
   logic [MCW-1:0]             mcnt_ff, mcnt_in;

   // result channel
   logic signed [DRIVE_W-1:0]  rsp_drive_ff, rsp_drive_in;
   logic                       rsp_done_ff, rsp_done_in;
   logic signed [NORM_W-1:0]   rsp_norm_ff, rsp_norm_in;

   // combinational helpers
   logic signed [WORK_W-1:0]   ang_wrapped;
   logic                       in_range;
   logic [AW-1:0]              want_sel;
   logic signed [EW-1:0]       e_val, e_abs;
   logic [AW-1:0]              e_mag;
   logic [AW:0]                rem_sh, rem_sub;
   logic                       rem_ge;
   logic [NW-1:0]              q_val;
   logic signed [NORM_W-1:0]   norm_new;
   logic [NORM_W-1:0]          norm_mag;
   logic                       finish;
   logic signed [SW:0]         sum_wide;
   logic signed [SW-1:0]       sum_new;
   logic signed [NXW-1:0]      norm_x;
   logic signed [SXW-1:0]      sum_x;
   logic                       in_norm;
   logic [NCW-1:0]             nidx;
   logic [CSW-1:0]             sidx;
   logic [CIW-1:0]             cidx;
   logic [CHUNK_W-1:0]         chunk;
   logic                       chunk_top;
   logic [GAIN_W-1:0]          gain;
   logic signed [CHUNK_W:0]    chunk_s;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PW-1:0]       prod_x, part;
   logic signed [PW-1:0]       acc_sh, lim;
   logic signed [DRIVE_W-1:0]  drive_clamp;

   // shortest signed path from cur to want, exact half turn counts positive
   function automatic logic signed [EW-1:0] shortest(input logic [AW-1:0] want,
                                                    input logic [AW-1:0] cur);
      logic signed [DW-1:0] d;
      logic signed [DW-1:0] d2;
      logic signed [DW-1:0] r;
      d  = $signed(DW'(want)) - $signed(DW'(cur));
      d2 = d <<< 1;
      if (d > 0) begin
         r = (d2 > FT_D) ? (d - FT_D) : d;
      end else begin
         r = (d2 > -FT_D) ? d : (d + FT_D);
      end
      return EW'(r);
   endfunction

   always_comb begin
      // angle wrap, one step a cycle
      in_range = (ang_ff >= 0) && (ang_ff < FT_WORK);
      if (ang_ff < 0) ang_wrapped = ang_ff + FT_WORK;
      else if (ang_ff >= FT_WORK) ang_wrapped = ang_ff - FT_WORK;
      else ang_wrapped = ang_ff;

      want_sel = (cmd.op == OP_START) ? ang_ff[AW-1:0] : target_ff;
      e_val    = shortest(want_sel, cur_ff);
      e_abs    = e_val[EW-1] ? -e_val : e_val;
      e_mag    = AW'(e_abs);

      // restoring divide step
      rem_sh  = {rem_ff[AW-1:0], quo_ff[NW-1]};
      rem_ge  = (rem_sh >= {1'b0, mag_ff});
      rem_sub = rem_sh - {1'b0, mag_ff};

      // quotient saturation and sign
      q_val = (mag_ff == '0) ? '0 : quo_ff;
      if (err_ff[EW-1]) begin
         norm_new = (q_val > NW'(NORM_NEG_MAG)) ? NORM_MIN : -$signed(NORM_W'(q_val));
      end else begin
         norm_new = (q_val > NW'(NORM_POS_MAX)) ? $signed(NORM_POS_MAX)
                                               : $signed(NORM_W'(q_val));
      end
      norm_mag = norm_new[NORM_W-1] ? NORM_W'(-norm_new) : NORM_W'(norm_new);
      finish   = (norm_mag <= NORM_W'(thr_ff));

      // saturating integral
      sum_wide = SW1'(sum_ff) + SW1'(norm_new);
      if (sum_wide > SUM_MAX) sum_new = SW'(SUM_MAX);
      else if (sum_wide < SUM_MIN) sum_new = SW'(SUM_MIN);
      else sum_new = SW'(sum_wide);

      // one chunk of a gain product per cycle
      norm_x  = NXW'(norm_ff);
      sum_x   = SXW'(sum_ff);
      in_norm = (mcnt_ff < MCW'(NORM_CH));
      nidx    = mcnt_ff[NCW-1:0];
      sidx    = CSW'(mcnt_ff - MCW'(NORM_CH));
      if (in_norm) begin
         chunk     = norm_x[CHUNK_W*nidx +: CHUNK_W];
         chunk_top = (nidx == NCW'(NORM_CH - 1));
         gain      = kp_ff;
         cidx      = CIW'(nidx);
      end else begin
         chunk     = sum_x[CHUNK_W*sidx +: CHUNK_W];
         chunk_top = (sidx == CSW'(SUM_CH - 1));
         gain      = ki_ff;
         cidx      = CIW'(sidx);
      end
      chunk_s = chunk_top ? {chunk[CHUNK_W-1], chunk} : {1'b0, chunk};
      gain_s  = {1'b0, gain};
      prod    = chunk_s * gain_s;
      prod_x  = PW'(prod);
      part    = prod_x <<< (CHUNK_W * cidx);

      // shift and clamp
      acc_sh = acc_ff >>> DRIVE_SHIFT;
      lim    = PW'({1'b0, max_ff});
      if (acc_sh > lim) drive_clamp = DRIVE_W'({1'b0, max_ff});
      else if (acc_sh < -lim) drive_clamp = -DRIVE_W'({1'b0, max_ff});
      else drive_clamp = DRIVE_W'(acc_sh);
   end

   always_comb begin
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      max_in       = max_ff;
      thr_in       = thr_ff;
      type_in      = type_ff;
      turn_in      = turn_ff;
      ang_in       = ang_ff;
      cur_in       = cur_ff;
      target_in    = target_ff;
      mag_in       = mag_ff;
      sum_in       = sum_ff;
      running_in   = running_ff;
      err_in       = err_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      norm_in      = norm_ff;
      drive_in     = drive_ff;
      done_in      = done_ff;
      acc_in       = acc_ff;
      mcnt_in      = mcnt_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_norm_in  = rsp_norm_ff;

      if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KP_GAIN:        kp_in  = csr_wdata;
            CSR_KI_GAIN:        ki_in  = csr_wdata;
            CSR_MAX_SPEED:      max_in = csr_wdata[SPEED_W-1:0];
            CSR_DONE_THRESHOLD: thr_in = csr_wdata[SPEED_W-1:0];
         endcase
      end

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            type_in = req_type;
            turn_in = req_turn_amount;
            ang_in  = WORK_W'(req_heading);
         end
         OP_WRAP: begin
            ang_in = ang_wrapped;
         end
         OP_TAKE_CUR: begin
            cur_in = ang_ff[AW-1:0];
            ang_in = ang_ff + WORK_W'(turn_ff);
         end
         OP_START: begin
            target_in  = ang_ff[AW-1:0];
            mag_in     = e_mag;
            sum_in     = '0;
            running_in = (e_mag != '0);
            drive_in   = '0;
            done_in    = (e_mag == '0);
            if (e_mag == '0) norm_in = '0;
            else norm_in = e_val[EW-1] ? -NORM_ONE : NORM_ONE;
         end
         OP_IDLE_RES: begin
            drive_in = '0;
            done_in  = 1'b1;
            norm_in  = '0;
         end
         OP_ERR: begin
            err_in  = e_val;
            rem_in  = '0;
            quo_in  = {e_mag, {NORM_FRAC{1'b0}}};
            dcnt_in = '0;
         end
         OP_DIV: begin
            rem_in  = rem_ge ? rem_sub : rem_sh;
            quo_in  = {quo_ff[NW-2:0], rem_ge};
            dcnt_in = dcnt_ff + 1'b1;
         end
         OP_NORM: begin
            norm_in    = norm_new;
            sum_in     = sum_new;
            done_in    = finish;
            running_in = !finish;
            acc_in     = '0;
            mcnt_in    = '0;
         end
         OP_MUL: begin
            acc_in  = acc_ff + part;
            mcnt_in = mcnt_ff + 1'b1;
         end
         OP_CLAMP: begin
            drive_in = drive_clamp;
         end
         OP_RESULT: begin
            rsp_drive_in = drive_ff;
            rsp_done_in  = done_ff;
            rsp_norm_in  = norm_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff      <= KP_RESET;
         ki_ff      <= KI_RESET;
         max_ff     <= MAX_SPEED_RESET;
         thr_ff     <= THRESHOLD_RESET;
         target_ff  <= '0;
         mag_ff     <= '0;
         sum_ff     <= '0;
         running_ff <= 1'b0;
         dcnt_ff    <= '0;
         mcnt_ff    <= '0;
      end else begin
         kp_ff      <= kp_in;
         ki_ff      <= ki_in;
         max_ff     <= max_in;
         thr_ff     <= thr_in;
         target_ff  <= target_in;
         mag_ff     <= mag_in;
         sum_ff     <= sum_in;
         running_ff <= running_in;
         dcnt_ff    <= dcnt_in;
         mcnt_ff    <= mcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      turn_ff      <= turn_in;
      ang_ff       <= ang_in;
      cur_ff       <= cur_in;
      err_ff       <= err_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      norm_ff      <= norm_in;
      drive_ff     <= drive_in;
      done_ff      <= done_in;
      acc_ff       <= acc_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_norm_ff  <= rsp_norm_in;
   end

   assign status.in_range = in_range;
   assign status.is_start = (type_ff == REQ_START);
   assign status.running  = running_ff;
   assign status.div_last = (dcnt_ff == DCW'(NW - 1));
   assign status.mul_last = (mcnt_ff == MCW'(MSTEPS - 1));

   assign rsp_drive      = rsp_drive_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_error_norm = rsp_norm_ff;

   `HPTC_ASSERT_NEVER(a_run_mag, clock, reset, running_ff && (mag_ff == '0))
   `HPTC_ASSERT_CLK(a_div_rem, clock, reset, (cmd.op == OP_DIV) |=> (rem_ff < {1'b0, mag_ff}))
   `HPTC_ASSERT_CLK(a_norm_done, clock, reset, (cmd.op == OP_NORM) |=> (running_ff != done_ff))

endmodule
